FILE: hdl/hash_join_on_node_id_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hash join engine
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ---------------------------------------------------------------------------
`ifndef HASH_JOIN_ON_NODE_ID_MACROS_SVH
`define HASH_JOIN_ON_NODE_ID_MACROS_SVH

// same-cycle implication
`define HJN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HJN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/hjn_pkg.sv
// ---------------------------------------------------------------------------
// Hash join package
// Defaults, hash constants and transaction codes of the hash join engine.
// ---------------------------------------------------------------------------
package hjn_pkg;

   localparam int NUM_BUCKETS_DEF  = 64;
   localparam int BUCKET_DEPTH_DEF = 16;
   localparam int PAYLOAD_BITS_DEF = 16;

   localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
   localparam int MIX_SHIFT1 = 30;
   localparam int MIX_SHIFT2 = 27;
   localparam int MIX_SHIFT3 = 31;

   localparam logic FUNC_BUILD = 1'b0;
   localparam logic FUNC_PROBE = 1'b1;

   typedef enum logic [1:0] {
      ST_MATCH    = 2'd0,
      ST_NO_MATCH = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

endpackage

FILE: hdl/hjn_hash.sv
// ---------------------------------------------------------------------------
// Bucket hash unit
// splitmix64 finaliser on one shared 32x32 multiplier, then a four bits per
// cycle remainder by the bucket count.
// ---------------------------------------------------------------------------
module hjn_hash #(
   parameter int NUM_BUCKETS = hjn_pkg::NUM_BUCKETS_DEF,
   localparam int BW = $clog2(NUM_BUCKETS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   key,
   output logic          done,
   output logic [BW-1:0] bucket
);

   localparam int DIGIT = 4;
   localparam int STEPS = 64 / DIGIT;
   localparam int SW    = $clog2(STEPS);
   localparam logic [BW:0] NB = (BW+1)'(NUM_BUCKETS);

   typedef enum logic [1:0] {H_IDLE, H_MUL, H_MOD} hstate_type;

   hstate_type    state_ff, state_in;
   logic [63:0]   x_ff, x_in;
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   prod_ff, prod_in;
   logic [1:0]    ph_ff, ph_in;
   logic          round_ff, round_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;

   logic [63:0]   mul_c;
   logic [31:0]   mul_a;
   logic [31:0]   mul_b;
   logic [63:0]   mul_p;
   logic [63:0]   msum;
   logic [BW:0]   t;
   logic [BW-1:0] r;

   assign mul_c = round_ff ? hjn_pkg::MIX_MUL2 : hjn_pkg::MIX_MUL1;
   assign mul_a = (ph_ff == 2'd2) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b = (ph_ff == 2'd1) ? mul_c[63:32] : mul_c[31:0];
   assign mul_p = 64'(mul_a) * 64'(mul_b);
   assign msum  = acc_ff + {prod_ff[31:0], 32'h0};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      ph_in    = ph_ff;
      round_in = round_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      r        = rem_ff;
      t        = '0;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               x_in     = key ^ (key >> hjn_pkg::MIX_SHIFT1);
               ph_in    = 2'd0;
               round_in = 1'b0;
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            ph_in = ph_ff + 2'd1;
            case (ph_ff)
               2'd0: prod_in = mul_p;
               2'd1: begin
                  prod_in = mul_p;
                  acc_in  = prod_ff;
               end
               2'd2: begin
                  prod_in = mul_p;
                  acc_in  = msum;
               end
               default: begin
                  if (!round_ff) begin
                     x_in     = msum ^ (msum >> hjn_pkg::MIX_SHIFT2);
                     round_in = 1'b1;
                  end else begin
                     x_in     = msum ^ (msum >> hjn_pkg::MIX_SHIFT3);
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = H_MOD;
                  end
               end
            endcase
         end
         H_MOD: begin
            for (int j = 0; j < DIGIT; j++) begin
               t = {r, x_ff[63-j]};
               if (t >= NB) begin
                  t = t - NB;
               end
               r = t[BW-1:0];
            end
            rem_in = r;
            x_in   = x_ff << DIGIT;
            cnt_in = cnt_ff + SW'(1);
            if (cnt_ff == SW'(STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = H_IDLE;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
         ph_ff    <= 2'd0;
         round_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         ph_ff    <= ph_in;
         round_ff <= round_in;
         cnt_ff   <= cnt_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

FILE: hdl/hash_join_on_node_id.sv
// ---------------------------------------------------------------------------
// Hash join engine on 64-bit node identifiers
// Build and probe an in-memory hash table bucketed by splitmix64.
// ---------------------------------------------------------------------------
// One transaction is worked on at a time. After reset a clearing pass zeroes
// the bucket fill counts with req_tready low. A build or a probe holds
// req_tready low from its acceptance until the engine is idle again; a
// result that waits on rsp_tready holds it low longer. The hash (on the
// shared 32x32 multiplier and sixteen remainder steps) comes first, and the
// bucket scan reads one stored entry per cycle unless a match waits on
// rsp_tready. Results of a probe come in insertion order, tlast on the
// final one; a successful build gives no result.
`include "hash_join_on_node_id_macros.svh"

module hash_join_on_node_id #(
   parameter int NUM_BUCKETS  = hjn_pkg::NUM_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = hjn_pkg::BUCKET_DEPTH_DEF,
   parameter int PAYLOAD_BITS = hjn_pkg::PAYLOAD_BITS_DEF,
   localparam int REQ_BITS = ((64 + PAYLOAD_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = ((64 + 2 * PAYLOAD_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,   // key, payload
   input  logic                req_tuser,   // func
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,   // match_key, probe_payload, build_payload
   output logic [1:0]          rsp_tuser,   // status
   output logic                rsp_tlast
);

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int FW = $clog2(BUCKET_DEPTH + 1);
   localparam int DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int AW = $clog2(DEPTH);
   localparam int PW = PAYLOAD_BITS;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_FILL, S_DECIDE, S_SCAN, S_END
   } state_type;

   state_type  state_ff, state_in;
   logic [BW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          func_ff, func_in;
   logic [63:0]   key_ff, key_in;
   logic [PW-1:0] pay_ff, pay_in;
   logic [BW-1:0] bucket_ff, bucket_in;
   logic [AW-1:0] base_ff, base_in;
   logic [FW-1:0] issue_ff, issue_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic          pend_ff, pend_in;
   logic [PW-1:0] pend_pay_ff, pend_pay_in;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   hjn_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [63:0]            rsp_key_ff, rsp_key_in;
   logic [PW-1:0]          rsp_ppay_ff, rsp_ppay_in;
   logic [PW-1:0]          rsp_bpay_ff, rsp_bpay_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [FW-1:0] fill_mem [NUM_BUCKETS];
   logic [FW-1:0] fill_rd_ff;
   logic          fill_we;
   logic [BW-1:0] fill_wa;
   logic [FW-1:0] fill_wd;

   logic [63:0]   key_mem [DEPTH];
   logic [PW-1:0] pay_mem [DEPTH];
   logic          store_we;
   logic [AW-1:0] store_wa;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [63:0]   rd_key_ff;
   logic [PW-1:0] rd_pay_ff;

   logic          hash_start;
   logic          hash_done;
   logic [BW-1:0] hash_bucket;

   logic out_free;
   logic hit;
   logic emit;
   logic advance;
   logic more;
   logic rsp_load;

   hjn_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (key_in),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign hit      = cmp_vld_ff && (rd_key_ff == key_ff);
   assign emit     = hit && pend_ff;
   assign advance  = !emit || out_free;
   assign more     = issue_ff < fill_rd_ff;
   assign rd_addr  = base_ff + AW'(issue_ff);
   assign store_wa = base_ff + AW'(fill_rd_ff);

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      bucket_in     = bucket_ff;
      base_in       = base_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = cmp_vld_ff;
      pend_in       = pend_ff;
      pend_pay_in   = pend_pay_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_ppay_in   = rsp_ppay_ff;
      rsp_bpay_in   = rsp_bpay_ff;
      rsp_last_in   = rsp_last_ff;
      fill_we       = 1'b0;
      fill_wa       = bucket_ff;
      fill_wd       = fill_rd_ff + FW'(1);
      store_we      = 1'b0;
      rd_en         = 1'b0;
      hash_start    = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            fill_we = 1'b1;
            fill_wa = clr_cnt_ff;
            fill_wd = '0;
            clr_cnt_in = clr_cnt_ff + BW'(1);
            if (clr_cnt_ff == BW'(NUM_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               func_in    = req_tuser;
               key_in     = req_tdata[63:0];
               pay_in     = req_tdata[64 +: PW];
               hash_start = 1'b1;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               bucket_in = hash_bucket;
               state_in  = S_FILL;
            end
         end
         S_FILL: begin
            base_in  = AW'(bucket_ff) * AW'(BUCKET_DEPTH);
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            pend_in = 1'b0;
            if (func_ff == hjn_pkg::FUNC_BUILD && fill_rd_ff != FW'(BUCKET_DEPTH)) begin
               store_we = 1'b1;
               fill_we  = 1'b1;
               state_in = S_IDLE;
            end else if (func_ff == hjn_pkg::FUNC_PROBE && fill_rd_ff != '0) begin
               issue_in   = '0;
               cmp_vld_in = 1'b0;
               state_in   = S_SCAN;
            end else begin
               state_in = S_END;
            end
         end
         S_SCAN: begin
            if (advance) begin
               rd_en      = more;
               cmp_vld_in = more;
               if (more) begin
                  issue_in = issue_ff + FW'(1);
               end
               if (hit) begin
                  pend_in     = 1'b1;
                  pend_pay_in = rd_pay_ff;
               end
               if (emit) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = hjn_pkg::ST_MATCH;
                  rsp_bpay_in   = pend_pay_ff;
                  rsp_last_in   = 1'b0;
               end
            end
            if (!cmp_vld_ff && !more) begin
               state_in = S_END;
            end
         end
         S_END: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_last_in = 1'b1;
               if (pend_ff) begin
                  rsp_status_in = hjn_pkg::ST_MATCH;
                  rsp_bpay_in   = pend_pay_ff;
               end else begin
                  rsp_status_in = (func_ff == hjn_pkg::FUNC_BUILD) ?
                                  hjn_pkg::ST_FULL : hjn_pkg::ST_NO_MATCH;
                  rsp_bpay_in   = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_key_in    = key_ff;
         rsp_ppay_in   = pay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         issue_ff      <= '0;
         cmp_vld_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         issue_ff      <= issue_in;
         cmp_vld_ff    <= cmp_vld_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      func_ff       <= func_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      bucket_ff     <= bucket_in;
      base_ff       <= base_in;
      pend_pay_ff   <= pend_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_ppay_ff   <= rsp_ppay_in;
      rsp_bpay_ff   <= rsp_bpay_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_wa] <= fill_wd;
      end
      fill_rd_ff <= fill_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         key_mem[store_wa] <= key_ff;
         pay_mem[store_wa] <= pay_ff;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_pay_ff <= pay_mem[rd_addr];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_bpay_ff, rsp_ppay_ff, rsp_key_ff});
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `HJN_ASSERT_NOW(a_load_free, rsp_load, out_free, "result loaded over a waiting transaction")
   `HJN_ASSERT_NOW(a_fill_bound, fill_we, fill_wd <= FW'(BUCKET_DEPTH), "bucket fill overrun")
   `HJN_ASSERT_NOW(a_scan_bound, state_ff == S_SCAN, issue_ff <= fill_rd_ff, "scan past fill")
   `HJN_ASSERT_NOW(a_hash_done, hash_done, state_ff == S_HASH, "hash done outside hash wait")
   `HJN_ASSERT_NEXT(a_start_busy, hash_start, !req_tready, "ready held during hash")

endmodule
